### rtl/core/tfm_pkg.sv
// Package for the topic filter matcher: command codes, wildcard characters,
// transfer payload types and the default filter capacity.
// No dependencies.
package tfm_pkg;

	// Default number of filter bytes the store can hold.
	localparam int unsigned MaxFilterBytes = 256;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TOPIC  = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] character;
	} item_t;

	typedef struct packed {
		logic match;
		logic filter_overflowed;
	} result_t;

	// One item handed from the input register to the matcher.
	typedef struct packed {
		logic  fire;
		item_t item;
	} step_t;

endpackage

### rtl/core/tfm_ram.sv
// Generic memory with one write port and two registered read ports.
// No dependencies.
module tfm_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 256,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr_a,
	input  logic [AddrW-1:0] raddr_b,
	output logic [Width-1:0] rdata_a,
	output logic [Width-1:0] rdata_b
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### rtl/core/tfm_match.sv
// Matcher core: filter store, filter position state and a two-byte window
// kept ahead of the position by reads from the store.
// Depends on tfm_pkg and tfm_ram.
module tfm_match #(
	parameter int unsigned MaxFilterBytes = tfm_pkg::MaxFilterBytes
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tfm_pkg::step_t    step,
	output tfm_pkg::result_t  result
);

	localparam int unsigned LenW  = $clog2(MaxFilterBytes + 1);
	localparam int unsigned AddrW = $clog2(MaxFilterBytes);

	typedef enum logic [1:0] {
		VERDICT_OPEN  = 2'd0,
		VERDICT_MATCH = 2'd1,
		VERDICT_FAIL  = 2'd2
	} verdict_t;

	logic [LenW-1:0]  len_q, len_n;
	logic [LenW-1:0]  pos_q, pos_n;
	logic             skip_q, skip_n;
	verdict_t         verdict_q, verdict_n;
	logic             ovf_q, ovf_n;
	logic [7:0]       win0_q, win0_n, win1_q, win1_n;
	logic [7:0]       head0_q, head0_n, head1_q, head1_n;
	logic             fwd_a_q, fwd_b_q;
	logic [7:0]       fwd_data_q;

	logic             we;
	logic [AddrW-1:0] waddr, raddr_a, raddr_b;
	logic [7:0]       rdata_a, rdata_b, view_a, view_b, ch;
	logic [LenW-1:0]  ra_full, rb_full;
	logic [LenW:0]    pos_plus1;
	logic             avail0, avail1, room;
	logic [1:0]       adv;
	logic             topic_skip, end_hit;
	verdict_t         topic_verdict;

	tfm_ram #(
		.Width(8),
		.Depth(MaxFilterBytes)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (ch),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign ch = step.item.character;

	// The read ports hold the bytes two and three places past the position.
	// A byte written in the cycle it was read is taken from the forward register.
	assign view_a = fwd_a_q ? fwd_data_q : rdata_a;
	assign view_b = fwd_b_q ? fwd_data_q : rdata_b;

	assign pos_plus1 = {1'b0, pos_q} + (LenW + 1)'(1);
	assign avail0    = pos_q < len_q;
	assign avail1    = pos_plus1 < {1'b0, len_q};
	assign room      = len_q < LenW'(MaxFilterBytes);
	assign waddr     = len_q[AddrW-1:0];

	// Decision for one topic byte.
	always_comb begin
		adv           = 2'd0;
		topic_skip    = skip_q;
		topic_verdict = verdict_q;
		if (verdict_q == VERDICT_OPEN) begin
			priority if (skip_q) begin
				if (ch == tfm_pkg::CH_SLASH) begin
					topic_skip = 1'b0;
					if (avail0 && win0_q == tfm_pkg::CH_SLASH) begin
						adv = 2'd1;
					end else begin
						topic_verdict = VERDICT_FAIL;
					end
				end
			end else if (!avail0) begin
				topic_verdict = VERDICT_FAIL;
			end else if (win0_q == tfm_pkg::CH_HASH) begin
				topic_verdict = VERDICT_MATCH;
			end else if (win0_q == tfm_pkg::CH_PLUS) begin
				adv        = 2'd1;
				topic_skip = 1'b1;
				if (ch == tfm_pkg::CH_SLASH) begin
					topic_skip = 1'b0;
					if (avail1 && win1_q == tfm_pkg::CH_SLASH) begin
						adv = 2'd2;
					end else begin
						topic_verdict = VERDICT_FAIL;
					end
				end
			end else if (win0_q == ch) begin
				adv = 2'd1;
			end else begin
				topic_verdict = VERDICT_FAIL;
			end
		end
	end

	// Verdict at the end of a topic.
	always_comb begin
		if (verdict_q != VERDICT_OPEN) begin
			end_hit = (verdict_q == VERDICT_MATCH);
		end else begin
			end_hit = !avail0
				|| win0_q == tfm_pkg::CH_HASH
				|| (win0_q == tfm_pkg::CH_SLASH && avail1 && win1_q == tfm_pkg::CH_HASH)
				|| (!skip_q && win0_q == tfm_pkg::CH_PLUS && !avail1);
		end
		result.match             = end_hit && !ovf_q;
		result.filter_overflowed = ovf_q;
	end

	// Next state.
	always_comb begin
		len_n     = len_q;
		pos_n     = pos_q;
		skip_n    = skip_q;
		verdict_n = verdict_q;
		ovf_n     = ovf_q;
		win0_n    = win0_q;
		win1_n    = win1_q;
		head0_n   = head0_q;
		head1_n   = head1_q;
		we        = 1'b0;
		if (step.fire) begin
			unique case (step.item.command)
				tfm_pkg::CMD_CLEAR: begin
					len_n     = '0;
					ovf_n     = 1'b0;
					pos_n     = '0;
					skip_n    = 1'b0;
					verdict_n = VERDICT_OPEN;
				end
				tfm_pkg::CMD_APPEND: begin
					if (room) begin
						we    = 1'b1;
						len_n = len_q + LenW'(1);
						if (len_q == LenW'(0)) begin
							head0_n = ch;
						end
						if (len_q == LenW'(1)) begin
							head1_n = ch;
						end
					end else begin
						ovf_n = 1'b1;
					end
					pos_n     = '0;
					skip_n    = 1'b0;
					verdict_n = VERDICT_OPEN;
					win0_n    = head0_n;
					win1_n    = head1_n;
				end
				tfm_pkg::CMD_TOPIC: begin
					pos_n     = pos_q + LenW'(adv);
					skip_n    = topic_skip;
					verdict_n = topic_verdict;
					unique case (adv)
						2'd1: begin
							win0_n = win1_q;
							win1_n = view_a;
						end
						2'd2: begin
							win0_n = view_a;
							win1_n = view_b;
						end
						default: begin
							win0_n = win0_q;
							win1_n = win1_q;
						end
					endcase
				end
				tfm_pkg::CMD_END: begin
					pos_n     = '0;
					skip_n    = 1'b0;
					verdict_n = VERDICT_OPEN;
					win0_n    = head0_q;
					win1_n    = head1_q;
				end
			endcase
		end
	end

	// Fetch the bytes that follow the window at the next position.
	assign ra_full = pos_n + LenW'(2);
	assign rb_full = pos_n + LenW'(3);
	assign raddr_a = ra_full[AddrW-1:0];
	assign raddr_b = rb_full[AddrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			pos_q     <= '0;
			skip_q    <= 1'b0;
			verdict_q <= VERDICT_OPEN;
			ovf_q     <= 1'b0;
			fwd_a_q   <= 1'b0;
			fwd_b_q   <= 1'b0;
		end else begin
			len_q     <= len_n;
			pos_q     <= pos_n;
			skip_q    <= skip_n;
			verdict_q <= verdict_n;
			ovf_q     <= ovf_n;
			fwd_a_q   <= we && (waddr == raddr_a);
			fwd_b_q   <= we && (waddr == raddr_b);
		end
	end

	always_ff @(posedge clk) begin
		win0_q     <= win0_n;
		win1_q     <= win1_n;
		head0_q    <= head0_n;
		head1_q    <= head1_n;
		fwd_data_q <= ch;
	end

endmodule

### rtl/core/topic_filter_matcher_unit.sv
// Top level of the topic filter matcher: input register, matcher core and
// result register. Depends on tfm_pkg and tfm_match.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, item);
// each carries a command and a character. Clear empties the filter and its
// overflow flag, append adds one filter byte, topic byte feeds one byte of
// the topic name, and end of topic produces exactly one transfer on the
// result channel (result_valid, result_stall, result) with the match bit
// and the overflow flag. Appends past the filter capacity are dropped and
// force every later result to no match until the next clear. Any filter
// change, and every end of topic, re-arms the matcher for a new topic.
// Throughput is one item per cycle while no end-of-topic item waits: the
// core keeps a two-byte window of the filter at the current position in
// registers, refilled every cycle by the two read ports of the filter store,
// so a topic byte that advances the position by two still finds its bytes
// ready. An end of topic goes through the input and the result register.
// After reset the filter is empty, both channels are idle and the store
// holds no meaningful data. While the receiver stalls, the result holds;
// topic and filter items keep flowing, and only an end-of-topic item waits
// in the input register, which then stalls the item channel.
module topic_filter_matcher_unit #(
	parameter int unsigned MaxFilterBytes = tfm_pkg::MaxFilterBytes
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tfm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tfm_pkg::result_t result
);

	logic             item_valid_s1;
	tfm_pkg::item_t   item_s1;
	logic             result_valid_q;
	tfm_pkg::result_t result_q;

	tfm_pkg::step_t   step;
	tfm_pkg::result_t core_result;
	logic             out_free, is_end, advance;

	// The result register can take a new result when it is empty or its
	// current result transfers in this cycle.
	assign out_free = !result_valid_q || !result_stall;
	assign is_end   = (item_s1.command == tfm_pkg::CMD_END);

	// Only an end-of-topic item needs room in the result register.
	assign advance    = item_valid_s1 && (!is_end || out_free);
	assign item_stall = item_valid_s1 && !advance;

	assign step.fire = advance;
	assign step.item = item_s1;

	tfm_match #(
		.MaxFilterBytes(MaxFilterBytes)
	) u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.result(core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				item_valid_s1 <= item_valid;
			end
			if (advance && is_end) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (advance && is_end) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### bench/tfm_bench_pkg.sv
`timescale 1ns / 1ps
// Checking side of the topic filter matcher bench: a predictor of the match
// verdict and the queue of results it expects. Depends on tfm_pkg.
package tfm_bench_pkg;
	import tfm_pkg::*;

	typedef enum logic [1:0] {
		VERDICT_OPEN,
		VERDICT_MATCH,
		VERDICT_FAIL
	} verdict_t;

	class match_checker;
		logic [7:0]  filter_bytes [MaxFilterBytes];
		int unsigned filter_len;
		int unsigned filter_pos;
		bit          in_plus_level;
		verdict_t    verdict;
		bit          overflowed;
		result_t     expected_results [$];
		int unsigned mismatches;

		function new();
			filter_len = 0;
			overflowed = 1'b0;
			mismatches = 0;
			rearm();
		endfunction

		function void rearm();
			filter_pos = 0;
			in_plus_level = 1'b0;
			verdict = VERDICT_OPEN;
		endfunction

		function bit filter_has(int unsigned pos, logic [7:0] value);
			return pos < filter_len && filter_bytes[pos] == value;
		endfunction

		// A '+' level ends at a topic '/'; the filter must continue with '/'.
		function void close_plus_level();
			in_plus_level = 1'b0;
			if (filter_has(filter_pos, CH_SLASH))
				filter_pos++;
			else
				verdict = VERDICT_FAIL;
		endfunction

		function void take_topic_byte(logic [7:0] c);
			logic [7:0] f;
			if (verdict != VERDICT_OPEN)
				return;
			if (in_plus_level) begin
				if (c == CH_SLASH)
					close_plus_level();
				return;
			end
			if (filter_pos >= filter_len) begin
				verdict = VERDICT_FAIL;
				return;
			end
			f = filter_bytes[filter_pos];
			if (f == CH_HASH) begin
				verdict = VERDICT_MATCH;
			end else if (f == CH_PLUS) begin
				filter_pos++;
				in_plus_level = 1'b1;
				if (c == CH_SLASH)
					close_plus_level();
			end else if (f == c) begin
				filter_pos++;
			end else begin
				verdict = VERDICT_FAIL;
			end
		endfunction

		function bit topic_matches();
			int unsigned p;
			p = filter_pos;
			if (verdict != VERDICT_OPEN)
				return verdict == VERDICT_MATCH;
			if (p >= filter_len)
				return 1'b1;
			if (filter_bytes[p] == CH_HASH)
				return 1'b1;
			if (filter_bytes[p] == CH_SLASH && filter_has(p + 1, CH_HASH))
				return 1'b1;
			if (!in_plus_level && filter_bytes[p] == CH_PLUS && p + 1 >= filter_len)
				return 1'b1;
			return 1'b0;
		endfunction

		function void note_item(item_t it);
			result_t r;
			case (it.command)
				CMD_CLEAR: begin
					filter_len = 0;
					overflowed = 1'b0;
					rearm();
				end
				CMD_APPEND: begin
					if (filter_len < MaxFilterBytes) begin
						filter_bytes[filter_len] = it.character;
						filter_len++;
					end else begin
						overflowed = 1'b1;
					end
					rearm();
				end
				CMD_TOPIC: begin
					take_topic_byte(it.character);
				end
				default: begin
					r.match = topic_matches() && !overflowed;
					r.filter_overflowed = overflowed;
					expected_results = {expected_results, r};
					rearm();
				end
			endcase
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result %b with no end of topic waiting", got));
				return;
			end
			want = expected_results.pop_front();
			if (got.match !== want.match)
				report($sformatf("match is %b, expected %b", got.match, want.match));
			if (got.filter_overflowed !== want.filter_overflowed)
				report($sformatf("filter_overflowed is %b, expected %b",
					got.filter_overflowed, want.filter_overflowed));
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

### bench/tb.sv
`timescale 1ns / 1ps
// Bench top for topic_filter_matcher_unit: directed and random item streams
// with random idling and stalls. Depends on tfm_pkg, tfm_bench_pkg and the RTL.
module tb;
	import tfm_pkg::*;
	import tfm_bench_pkg::*;

	// Number of items in the random part, the part of it run without any idling,
	// the length of the long receiver hold-off in cycles, and how many bytes of
	// the full filter one topic walks.
	localparam int RandomItems = 150;
	localparam int QuietTail = 30;
	localparam int LongHold = 200;
	localparam int PartialWalk = 24;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Filter and topic strings of the current random scenario.
	logic [7:0] filter_text [$];
	logic [7:0] topic_text [$];

	bit          sender_idles = 1'b0;
	bit          receiver_idles = 1'b0;
	bit          hold_results = 1'b0;
	int unsigned items_sent = 0;

	match_checker matcher_model = new();

	topic_filter_matcher_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are observed at the rising edge. Every accepted item is fed
	// to the predictor, and every accepted result is checked against the oldest
	// expectation. An end of topic passes the input register and the result
	// register first, so the order of the two calls does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				matcher_model.note_item(item);
			if (result_valid && !result_stall)
				matcher_model.check_result(result);
		end
	end

	// Receiver. It stalls in random bursts while allowed to, and once holds off
	// for a long stretch on request so that a pending end of topic backs up into
	// the input register and the item channel stalls.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_results) begin
				result_stall <= 1'b1;
				repeat (LongHold) @(negedge clk);
				result_stall <= 1'b0;
				hold_results = 1'b0;
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Offers one item, possibly after an idle burst, and returns at the falling
	// edge after its transfer. Valid stays high between items but for idle bursts.
	task automatic send(cmd_t cmd, logic [7:0] ch);
		item_t it;
		it.command = cmd;
		it.character = ch;
		if (sender_idles && $urandom_range(0, 9) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Clear and end of topic ignore their character, so it is random.
	task automatic send_bare(cmd_t cmd);
		send(cmd, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_bytes(cmd_t cmd, ref logic [7:0] text [$]);
		foreach (text[i])
			send(cmd, text[i]);
	endtask

	// Stops offering items until every expected result has been transferred.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (matcher_model.pending() != 0);
	endtask

	// Mostly a small alphabet so that literal levels often agree, with the
	// byte extremes, any byte, and now and then a wildcard or separator.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 7))
			0, 1, 2: return "a";
			3: return "b";
			4: return 8'h00;
			5: return 8'hFF;
			6: return 8'($urandom_range(0, 255));
			default: begin
				case ($urandom_range(0, 2))
					0: return CH_SLASH;
					1: return CH_PLUS;
					default: return CH_HASH;
				endcase
			end
		endcase
	endfunction

	// A filter of one to four levels: '+' levels, short literal levels, and
	// sometimes a closing '#'.
	task automatic build_filter();
		int levels;
		int kind;
		filter_text.delete();
		levels = $urandom_range(1, 4);
		for (int i = 0; i < levels; i++) begin
			if (i != 0)
				filter_text = {filter_text, CH_SLASH};
			kind = $urandom_range(0, 9);
			if (kind < 3)
				filter_text = {filter_text, CH_PLUS};
			else if (kind < 6 && i == levels - 1)
				filter_text = {filter_text, CH_HASH};
			else
				repeat ($urandom_range(0, 3)) filter_text = {filter_text, pick_char()};
		end
	endtask

	// A topic shaped after the filter so that many of them match: each '+'
	// becomes a random level, '#' becomes a random tail or vanishes (at times
	// together with the '/' before it), literals are copied with rare damage,
	// and now and then a level is added or a byte cut off at the end.
	task automatic build_topic();
		topic_text.delete();
		foreach (filter_text[i]) begin
			if (filter_text[i] == CH_PLUS) begin
				repeat ($urandom_range(0, 3)) topic_text = {topic_text, pick_char()};
			end else if (filter_text[i] == CH_HASH) begin
				case ($urandom_range(0, 2))
					0: begin
						if (topic_text.size() != 0 && topic_text[$] == CH_SLASH)
							void'(topic_text.pop_back());
					end
					1: ;
					default: repeat ($urandom_range(1, 6))
						topic_text = {topic_text, pick_char()};
				endcase
			end else if ($urandom_range(0, 9) == 0) begin
				topic_text = {topic_text, pick_char()};
			end else begin
				topic_text = {topic_text, filter_text[i]};
			end
		end
		case ($urandom_range(0, 7))
			0: begin
				topic_text = {topic_text, CH_SLASH};
				topic_text = {topic_text, pick_char()};
			end
			1: if (topic_text.size() != 0) void'(topic_text.pop_back());
			default: ;
		endcase
	endtask

	initial begin
		bit hold_done;
		bit pause_done;
		logic [7:0] fill_byte;
		hold_done = 1'b0;
		pause_done = 1'b0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;

		// Directed part.
		// Empty filter against an empty topic: the filter is used up, a match.
		send_bare(CMD_END);
		// A zero byte with no filter byte left: no match.
		send(CMD_TOPIC, 8'h00);
		send_bare(CMD_END);
		// Filter "+/#": a trailing "/#" also matches the parent level.
		send(CMD_APPEND, CH_PLUS);
		send(CMD_APPEND, CH_SLASH);
		send(CMD_APPEND, CH_HASH);
		send(CMD_TOPIC, "a");
		send_bare(CMD_END);
		// An append in the middle of a topic re-arms the matcher, so only
		// "q/" is matched against "+/#" followed by a zero byte.
		send(CMD_TOPIC, "x");
		send(CMD_TOPIC, "y");
		send(CMD_APPEND, 8'h00);
		send(CMD_TOPIC, "q");
		send(CMD_TOPIC, CH_SLASH);
		send_bare(CMD_END);
		// Filter 0xFF then '+': a '/' that ends the '+' level finds no '/'
		// in the filter, so no match.
		send_bare(CMD_CLEAR);
		send(CMD_APPEND, 8'hFF);
		send(CMD_APPEND, CH_PLUS);
		send(CMD_TOPIC, 8'hFF);
		send(CMD_TOPIC, "z");
		send(CMD_TOPIC, CH_SLASH);
		send_bare(CMD_END);
		// A final '+' matches an empty level.
		send(CMD_TOPIC, 8'hFF);
		send_bare(CMD_END);
		// Once the verdict is no match, later topic bytes change nothing.
		send(CMD_TOPIC, 8'h01);
		send(CMD_TOPIC, 8'h02);
		send_bare(CMD_END);

		// Full filter: every entry written, a topic that walks its first bytes,
		// then one append too many, whose flag forces no match until a clear.
		send_bare(CMD_CLEAR);
		filter_text.delete();
		repeat (MaxFilterBytes) begin
			case ($urandom_range(0, 3))
				0: fill_byte = "a";
				1: fill_byte = "b";
				2: fill_byte = CH_SLASH;
				default: fill_byte = 8'h00;
			endcase
			filter_text = {filter_text, fill_byte};
		end
		send_bytes(CMD_APPEND, filter_text);
		topic_text.delete();
		for (int i = 0; i < PartialWalk; i++)
			topic_text = {topic_text, filter_text[i]};
		send_bytes(CMD_TOPIC, topic_text);
		send_bare(CMD_END);
		send(CMD_APPEND, CH_HASH);
		send(CMD_TOPIC, filter_text[0]);
		send_bare(CMD_END);
		send_bare(CMD_CLEAR);
		send_bare(CMD_END);

		// Random part: mostly a filter and one to three topics against it,
		// sometimes without a clear so that the filter grows, and now and then
		// a burst of arbitrary items. Partway through, the receiver holds off
		// for a long stretch while items keep coming; later the sender pauses
		// until every result is in. The last stretch runs without idling.
		items_sent = 0;
		while (items_sent < RandomItems) begin
			if (items_sent >= RandomItems - QuietTail) begin
				sender_idles = 1'b0;
				receiver_idles = 1'b0;
			end
			if (!hold_done && items_sent >= 40) begin
				hold_results = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_sent >= 90) begin
				wait_for_results();
				pause_done = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(3, 10))
					send(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				build_filter();
				if ($urandom_range(0, 4) != 0)
					send_bare(CMD_CLEAR);
				send_bytes(CMD_APPEND, filter_text);
				repeat ($urandom_range(1, 3)) begin
					build_topic();
					send_bytes(CMD_TOPIC, topic_text);
					send_bare(CMD_END);
				end
			end
		end

		wait_for_results();
		repeat (8) @(negedge clk);
		if (matcher_model.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/tfm_pkg.sv
rtl/core/tfm_ram.sv
rtl/core/tfm_match.sv
rtl/core/topic_filter_matcher_unit.sv
bench/tfm_bench_pkg.sv
bench/tb.sv
